/* hdl/rle_pkg.sv */
// Shared constants and types for the bit run-length text encoder.
// No dependencies.
`timescale 1ns / 1ps

package rle_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;	// '0'
	localparam logic [7:0] CH_COLON = 8'h3A;	// ':'
	localparam logic [7:0] CH_COMMA = 8'h2C;	// ','
	localparam logic [7:0] CH_NINE  = 8'h39;	// '9'

	// runs of this length or more are written in the long text form
	localparam int LONG_RUN = 6;

	localparam logic [15:0] BLOCK_LENGTH_RESET = 16'd1024;

	typedef struct packed {
		logic last;		// last character caused by one input item
		logic eob;		// final character of a block
	} rle_mark_t;

endpackage

/* hdl/rle_fifo.sv */
// Small register-based queue between the front and back parts.
// No package dependencies.
`timescale 1ns / 1ps

module rle_fifo #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* hdl/rle_front.sv */
// Front part: tracks runs and block fill, queues the runs that each bit closes.
// Depends on rle_pkg.
`timescale 1ns / 1ps

module rle_front
	import rle_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [15:0]                 block_length,
	input  logic                        accept,
	input  logic                        bit_value,
	input  logic                        end_of_stream,
	output logic                        wr,
	// {a_valid, a_bit, a_len, b_valid, b_bit, b_len}
	output logic [2*COUNT_BITS+3:0]     entry
);

	logic                  run_bit_q, run_open_q;
	logic [COUNT_BITS-1:0] run_len_q, new_len;
	logic [15:0]           fill_q, fill_nx, limit;
	logic                  same, prev_valid, close;

	assign same       = run_open_q && (bit_value == run_bit_q);
	assign prev_valid = run_open_q && !same;
	assign new_len    = !same ? COUNT_BITS'(1) :
	                    (&run_len_q) ? run_len_q : run_len_q + COUNT_BITS'(1);
	assign fill_nx    = fill_q + 16'd1;
	assign limit      = (block_length == 16'd0) ? 16'd1 : block_length;
	// fill wrapping to zero also closes the block
	assign close      = end_of_stream || (fill_nx >= limit) || (fill_nx == 16'd0);

	assign wr    = accept && (prev_valid || close);
	assign entry = {prev_valid, run_bit_q, run_len_q, close, bit_value, new_len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_bit_q  <= 1'b0;
			run_open_q <= 1'b0;
			run_len_q  <= '0;
			fill_q     <= '0;
		end else if (accept) begin
			if (close) begin
				run_bit_q  <= 1'b0;
				run_open_q <= 1'b0;
				run_len_q  <= '0;
				fill_q     <= '0;
			end else begin
				run_bit_q  <= bit_value;
				run_open_q <= 1'b1;
				run_len_q  <= new_len;
				fill_q     <= fill_nx;
			end
		end
	end

endmodule

/* hdl/rle_back.sv */
// Back part: turns queued runs into ASCII characters, one per cycle while popped.
// Long runs go through a bit-serial binary to BCD conversion. Depends on rle_pkg.
`timescale 1ns / 1ps

module rle_back
	import rle_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [2*COUNT_BITS+3:0] entry,
	input  logic                    entry_valid,
	output logic                    entry_pop,
	output logic [7:0]              out_char,
	output rle_mark_t               out_mark,
	output logic                    empty,
	input  logic                    pop
);

	// decimal digits needed for 2^COUNT_BITS - 1
	localparam int NDIG = (COUNT_BITS * 30103) / 100000 + 1;
	localparam int CW   = $clog2(COUNT_BITS + 1);
	localparam int DW   = $clog2(NDIG + 1);
	localparam int BW   = 4 * NDIG;

	typedef enum logic [3:0] {
		S_IDLE, S_SHORT, S_CONV, S_LEAD, S_COLON1, S_DIGIT, S_COMMA, S_BIT, S_COLON2
	} state_t;

	state_t                state_q;
	logic                  bit_q, final_q, is_b_q;
	logic [COUNT_BITS-1:0] len_q, bin_q;
	logic [BW-1:0]         bcd_q, bcd_adj, bcd_nx;
	logic [CW-1:0]         cnt_q;
	logic [DW-1:0]         dig_q;
	logic                  b_pend_q, pb_bit_q;
	logic [COUNT_BITS-1:0] pb_len_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	rle_mark_t             mark_q;

	logic                  e_a_valid, e_a_bit, e_b_valid, e_b_bit;
	logic [COUNT_BITS-1:0] e_a_len, e_b_len;
	logic                  ld_bit, ld_is_b, ld_final, load;
	logic [COUNT_BITS-1:0] ld_len;
	logic                  emit_en, run_end, can_emit, step;
	logic [7:0]            emit_char, bit_char;
	logic [3:0]            top_dig;

	assign {e_a_valid, e_a_bit, e_a_len, e_b_valid, e_b_bit, e_b_len} = entry;

	assign ld_bit   = b_pend_q ? pb_bit_q : (e_a_valid ? e_a_bit : e_b_bit);
	assign ld_len   = b_pend_q ? pb_len_q : (e_a_valid ? e_a_len : e_b_len);
	assign ld_is_b  = b_pend_q || !e_a_valid;
	assign ld_final = ld_is_b || !e_b_valid;

	assign entry_pop = (state_q == S_IDLE) && entry_valid;
	assign bit_char  = CH_ZERO | {7'd0, bit_q};
	assign top_dig   = bcd_q[BW-1 -: 4];
	assign can_emit  = !out_valid_q || pop;

	always_comb begin
		emit_en   = 1'b0;
		run_end   = 1'b0;
		emit_char = bit_char;
		unique case (state_q)
			S_SHORT: begin
				emit_en = 1'b1;
				run_end = (len_q == COUNT_BITS'(1));
			end
			S_COLON1: begin
				emit_en   = 1'b1;
				emit_char = CH_COLON;
			end
			S_DIGIT: begin
				emit_en   = 1'b1;
				emit_char = CH_ZERO + {4'd0, top_dig};
			end
			S_COMMA: begin
				emit_en   = 1'b1;
				emit_char = CH_COMMA;
			end
			S_BIT: begin
				emit_en = 1'b1;
			end
			S_COLON2: begin
				emit_en   = 1'b1;
				emit_char = CH_COLON;
				run_end   = 1'b1;
			end
			S_IDLE, S_CONV, S_LEAD: begin
				emit_en = 1'b0;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	assign step = emit_en && can_emit;
	assign load = entry_pop || (step && run_end && b_pend_q);

	// double dabble: add 3 to any digit of 5 or more, then shift one bit in
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
			                                              : bcd_q[4*i +: 4];
		end
		bcd_nx = {bcd_adj[BW-2:0], bin_q[COUNT_BITS-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			b_pend_q    <= 1'b0;
			out_valid_q <= 1'b0;
			bit_q       <= 1'b0;
			final_q     <= 1'b0;
			is_b_q      <= 1'b0;
			len_q       <= '0;
			bin_q       <= '0;
			bcd_q       <= '0;
			cnt_q       <= '0;
			dig_q       <= '0;
			pb_bit_q    <= 1'b0;
			pb_len_q    <= '0;
			char_q      <= '0;
			mark_q      <= '0;
		end else begin
			// output register
			if (step) begin
				out_valid_q <= 1'b1;
				char_q      <= emit_char;
				mark_q.last <= run_end && final_q;
				mark_q.eob  <= run_end && final_q && is_b_q;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end

			if (load) begin
				bit_q   <= ld_bit;
				len_q   <= ld_len;
				bin_q   <= ld_len;
				bcd_q   <= '0;
				cnt_q   <= CW'(COUNT_BITS);
				final_q <= ld_final;
				is_b_q  <= ld_is_b;
				state_q <= (ld_len >= COUNT_BITS'(LONG_RUN)) ? S_CONV : S_SHORT;
				if (entry_pop) begin
					b_pend_q <= e_a_valid && e_b_valid;
					pb_bit_q <= e_b_bit;
					pb_len_q <= e_b_len;
				end else begin
					b_pend_q <= 1'b0;
				end
			end else begin
				unique case (state_q)
					S_IDLE: begin
						state_q <= S_IDLE;
					end
					S_SHORT: begin
						if (step) begin
							len_q <= len_q - COUNT_BITS'(1);
							if (run_end) begin
								state_q <= S_IDLE;
							end
						end
					end
					S_CONV: begin
						bcd_q <= bcd_nx;
						bin_q <= bin_q << 1;
						cnt_q <= cnt_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							state_q <= S_LEAD;
							dig_q   <= DW'(NDIG);
						end
					end
					S_LEAD: begin
						// drop leading zero digits
						if (top_dig == 4'd0 && dig_q > DW'(1)) begin
							bcd_q <= {bcd_q[BW-5:0], 4'd0};
							dig_q <= dig_q - DW'(1);
						end else begin
							state_q <= S_COLON1;
						end
					end
					S_COLON1: begin
						if (step) begin
							state_q <= S_DIGIT;
						end
					end
					S_DIGIT: begin
						if (step) begin
							bcd_q <= {bcd_q[BW-5:0], 4'd0};
							dig_q <= dig_q - DW'(1);
							if (dig_q == DW'(1)) begin
								state_q <= S_COMMA;
							end
						end
					end
					S_COMMA: begin
						if (step) begin
							state_q <= S_BIT;
						end
					end
					S_BIT: begin
						if (step) begin
							state_q <= S_COLON2;
						end
					end
					S_COLON2: begin
						if (step) begin
							state_q <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign out_char = char_q;
	assign out_mark = mark_q;
	assign empty    = !out_valid_q;

endmodule

/* hdl/bit_run_length_text_encoder.sv */
// Top level of the bit run-length text encoder: front, run queue and back.
// Depends on rle_pkg, rle_front, rle_fifo and rle_back.
`timescale 1ns / 1ps

// Takes one bit per push and writes runs of equal bits as ASCII text, one
// character per pop: runs shorter than six as repeated '0'/'1', runs of six
// or more as ":<length>,<bit>:". Blocks of block_length bits (0 acts as 1), or a
// bit with end_of_stream set, close the current run and restart run
// tracking. A push is taken every cycle while the run queue (QUEUE_DEPTH
// entries, one per bit that ends a run) has room; bits that only extend a run
// never enter the queue. The back end emits one character per cycle while its
// output is popped, and takes each new queue entry in its idle state, where it
// emits nothing. A long run first goes through the serial binary-to-decimal
// converter and then drops its leading zero digits before its first ':',
// emitting nothing meanwhile.
// The configuration write is always ready and should be used only while idle.

module bit_run_length_text_encoder
	import rle_pkg::*;
#(
	parameter int COUNT_BITS  = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        push,
	output logic        full,
	input  logic        bit_value,
	input  logic        end_of_stream,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_char,
	output logic        last_of_item,
	output logic        end_of_block
);

	localparam int EW = 2 * COUNT_BITS + 4;

	logic [15:0]   block_length_q;
	logic          accept, fifo_wr, fifo_rd, fifo_full, fifo_empty;
	logic [EW-1:0] wr_entry, rd_entry;
	rle_mark_t     mark;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= BLOCK_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			block_length_q <= cfg_data;
		end
	end

	assign full   = fifo_full;
	assign accept = push && !fifo_full;

	rle_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.block_length  (block_length_q),
		.accept        (accept),
		.bit_value     (bit_value),
		.end_of_stream (end_of_stream),
		.wr            (fifo_wr),
		.entry         (wr_entry)
	);

	rle_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (fifo_wr),
		.wr_data (wr_entry),
		.rd      (fifo_rd),
		.rd_data (rd_entry),
		.full    (fifo_full),
		.empty   (fifo_empty)
	);

	rle_back #(.COUNT_BITS(COUNT_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry       (rd_entry),
		.entry_valid (!fifo_empty),
		.entry_pop   (fifo_rd),
		.out_char    (out_char),
		.out_mark    (mark),
		.empty       (empty),
		.pop         (pop)
	);

	assign last_of_item = mark.last;
	assign end_of_block = mark.eob;

	// a block end is always the last character of its item
	a_eob_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && end_of_block) |-> last_of_item)
		else $error("end_of_block without last_of_item");

	// the final bit of the stream always queues the closing run
	a_eos_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && end_of_stream) |-> fifo_wr)
		else $error("end_of_stream bit did not queue a run");

	// only legal characters reach the output
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_char == CH_COLON || out_char == CH_COMMA ||
		            (out_char >= CH_ZERO && out_char <= CH_NINE)))
		else $error("illegal output character");

endmodule
